[sv/pus_pkg.sv]
// shared types, constants and helpers for the png scanline unfilter
`timescale 1ns / 1ps
`default_nettype none

package pus_pkg;

   // default geometry
   localparam int DEF_MAX_WIDTH       = 4096;
   localparam int DEF_BYTES_PER_PIXEL = 4;

   // register file
   localparam int   CSR_ADDR_W       = 3;
   localparam int   CSR_DATA_W       = 32;
   localparam int   IMAGE_WIDTH_W    = 13;
   localparam int   IMAGE_HEIGHT_W   = 16;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // highest legal filter code
   localparam logic [7:0] FILTER_MAX = 8'd4;

   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4,
      FLT_BAD   = 3'd5
   } filter_type;

   // one sample on its way from the counter stage to reconstruction
   typedef struct packed {
      logic [7:0] raw;
      filter_type filter;
      logic       first_row;
      logic       first_pixel;
      logic       row_end;
      logic       image_end;
   } pus_item_type;

   // paeth predictor: nearest of left, up, up-left to left + up - up-left
   function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] p;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
      da = p - $signed({2'b00, a});
      db = p - $signed({2'b00, b});
      dc = p - $signed({2'b00, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      else if (db <= dc) return b;
      else return c;
   endfunction

endpackage

`default_nettype wire

[sv/png_scanline_unfilter.sv]
// top level of the png scanline unfilter with its register file
`timescale 1ns / 1ps
`default_nettype none

// Reverses the PNG row filters (None, Sub, Up, Average, Paeth) of a
// non-interlaced 8-bit RGBA stream fed one inflated byte per transaction.
// Each row starts with a filter byte, which produces no result, followed by
// image_width*4 samples that each produce one reconstructed byte via the
// sample stage and result registers. The block takes one byte per cycle
// while rsp_stall is low. The previous row lives in a single line store
// RAM: each sample reads its column on acceptance and writes the result
// back on leaving the stage, always to a different column. Filter codes
// above 4 pass samples through with bad_filter set. After the last row the
// next byte starts a new image. image_width and image_height are written
// at byte offsets 0 and 4 and should only change while idle.
module png_scanline_unfilter #(
   parameter int MAX_WIDTH       = pus_pkg::DEF_MAX_WIDTH,
   parameter int BYTES_PER_PIXEL = pus_pkg::DEF_BYTES_PER_PIXEL
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic [7:0]                      req_data_byte,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [7:0]                      rsp_pixel_byte,
   output logic                                 rsp_row_end,
   output logic                                 rsp_image_end,
   output logic                                 rsp_bad_filter,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pus_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pus_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pus_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   import pus_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [IMAGE_WIDTH_W-1:0]  width_ff, width_in;
   logic [IMAGE_HEIGHT_W-1:0] height_ff, height_in;
   logic                      csr_write;

   logic                      b_valid;
   pus_item_type              b_item;
   logic [ADDR_W-1:0]         b_addr;
   logic                      b_take;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [7:0]                rd_data;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [7:0]                wr_data;

   // register file write
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[IMAGE_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[IMAGE_HEIGHT_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_W'(1);
         height_ff <= IMAGE_HEIGHT_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // register file read
   always_comb begin
      case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // counters and sample stage
   pus_ctrl #(
      .MAX_WIDTH       (MAX_WIDTH),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .cfg_width     (width_ff),
      .cfg_height    (height_ff),
      .b_take        (b_take),
      .b_valid       (b_valid),
      .b_item        (b_item),
      .b_addr        (b_addr),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   // previous row
   pus_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // reconstruction and result register
   pus_recon #(
      .ADDR_W          (ADDR_W),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_recon (
      .clock          (clock),
      .reset          (reset),
      .b_valid        (b_valid),
      .b_item         (b_item),
      .b_addr         (b_addr),
      .up_byte        (rd_data),
      .b_take         (b_take),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

   // line store read and write never meet on one column
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("line store read and write hit the same column");

endmodule

`default_nettype wire

[sv/pus_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/pus_ctrl.sv]
// row and column sequencing, line store read issue and sample stage register
`timescale 1ns / 1ps
`default_nettype none

module pus_ctrl #(
   parameter int MAX_WIDTH       = 4096,
   parameter int BYTES_PER_PIXEL = 4,
   localparam int LINE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL,
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
   localparam int COL_W      = $clog2(LINE_DEPTH + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic [7:0]                        req_data_byte,
   output logic                                   req_stall,
   input  wire logic [pus_pkg::IMAGE_WIDTH_W-1:0] cfg_width,
   input  wire logic [pus_pkg::IMAGE_HEIGHT_W-1:0] cfg_height,
   input  wire logic                              b_take,
   output logic                                   b_valid,
   output pus_pkg::pus_item_type                  b_item,
   output logic      [ADDR_W-1:0]                 b_addr,
   output logic                                   rd_en,
   output logic      [ADDR_W-1:0]                 rd_addr
);

   import pus_pkg::*;

   localparam logic [COL_W-1:0] BPP_COL = COL_W'(BYTES_PER_PIXEL);

   logic                      awaiting_ff, awaiting_in;
   logic                      first_row_ff, first_row_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [IMAGE_HEIGHT_W-1:0] row_ff, row_in;
   filter_type                filter_ff, filter_in;
   logic                      b_valid_ff, b_valid_in;
   pus_item_type              b_item_ff, b_item_in;
   logic [ADDR_W-1:0]         b_addr_ff, b_addr_in;

   logic                      hold;
   logic                      accept;
   logic [31:0]               width_eff;
   logic [COL_W-1:0]          stride;
   logic [IMAGE_HEIGHT_W-1:0] height_eff;
   logic [COL_W-1:0]          col_next;
   logic [IMAGE_HEIGHT_W-1:0] row_next;
   logic                      row_end;
   logic                      image_end;

   // handshake: the sample stage blocks input only while it cannot drain
   assign hold      = b_valid_ff & ~b_take;
   assign req_stall = hold;
   assign accept    = req_valid & ~hold;

   // effective row length and image height
   always_comb begin
      width_eff = {{(32 - IMAGE_WIDTH_W){1'b0}}, cfg_width};
      if (width_eff == 32'd0) width_eff = 32'd1;
      if (width_eff > 32'(MAX_WIDTH)) width_eff = 32'(MAX_WIDTH);
      stride     = COL_W'(width_eff * 32'(BYTES_PER_PIXEL));
      height_eff = (cfg_height == '0) ? IMAGE_HEIGHT_W'(1) : cfg_height;
   end

   // end of row and end of image detection
   always_comb begin
      col_next  = col_ff + COL_W'(1);
      row_next  = row_ff + IMAGE_HEIGHT_W'(1);
      row_end   = (col_next >= stride);
      image_end = row_end & ((row_next >= height_eff) | (row_next == '0));
   end

   // counter next state
   always_comb begin
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      filter_in    = filter_ff;
      if (accept) begin
         if (awaiting_ff) begin
            awaiting_in = 1'b0;
            col_in      = '0;
            filter_in   = (req_data_byte > FILTER_MAX) ? FLT_BAD
                                                       : filter_type'(req_data_byte[2:0]);
         end else if (row_end) begin
            awaiting_in = 1'b1;
            col_in      = '0;
            if (image_end) begin
               row_in       = '0;
               first_row_in = 1'b1;
            end else begin
               row_in       = row_next;
               first_row_in = 1'b0;
            end
         end else begin
            col_in = col_next;
         end
      end
   end

   // sample stage next state
   always_comb begin
      b_valid_in = b_valid_ff;
      b_item_in  = b_item_ff;
      b_addr_in  = b_addr_ff;
      if (accept && !awaiting_ff) begin
         b_valid_in            = 1'b1;
         b_item_in.raw         = req_data_byte;
         b_item_in.filter      = filter_ff;
         b_item_in.first_row   = first_row_ff;
         b_item_in.first_pixel = (col_ff < BPP_COL);
         b_item_in.row_end     = row_end;
         b_item_in.image_end   = image_end;
         b_addr_in             = col_ff[ADDR_W-1:0];
      end else if (b_take) begin
         b_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         filter_ff    <= FLT_NONE;
         b_valid_ff   <= 1'b0;
      end else begin
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         filter_ff    <= filter_in;
         b_valid_ff   <= b_valid_in;
      end
   end

   // sample payload
   always_ff @(posedge clock) begin
      b_item_ff <= b_item_in;
      b_addr_ff <= b_addr_in;
   end

   // the line store is read as the sample enters the stage
   assign rd_en   = accept & ~awaiting_ff;
   assign rd_addr = col_ff[ADDR_W-1:0];

   assign b_valid = b_valid_ff;
   assign b_item  = b_item_ff;
   assign b_addr  = b_addr_ff;

   // a filter byte always opens the row at column zero
   a_col_zero_at_filter: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> col_ff == '0)
      else $error("column count not zero while waiting for filter byte");

   // the last sample of a row is followed by a filter byte
   a_row_end_awaits: assert property (@(posedge clock) disable iff (reset)
      accept && !awaiting_ff && row_end |=> awaiting_ff)
      else $error("row ended without returning to filter byte");

   // a stalled sample keeps its line store address
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_take |=> b_valid_ff && $stable(b_addr_ff))
      else $error("sample stage lost a pending sample");

endmodule

`default_nettype wire

[sv/pus_recon.sv]
// filter reversal, neighbor history and result register
`timescale 1ns / 1ps
`default_nettype none

module pus_recon #(
   parameter int ADDR_W          = 14,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  b_valid,
   input  wire pus_pkg::pus_item_type b_item,
   input  wire logic [ADDR_W-1:0]     b_addr,
   input  wire logic [7:0]            up_byte,
   output logic                       b_take,
   output logic                       wr_en,
   output logic      [ADDR_W-1:0]     wr_addr,
   output logic      [7:0]            wr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [7:0]            rsp_pixel_byte,
   output logic                       rsp_row_end,
   output logic                       rsp_image_end,
   output logic                       rsp_bad_filter
);

   import pus_pkg::*;

   logic [7:0] left_ff   [BYTES_PER_PIXEL];
   logic [7:0] upleft_ff [BYTES_PER_PIXEL];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_byte_ff;
   logic       rsp_row_end_ff;
   logic       rsp_image_end_ff;
   logic       rsp_bad_filter_ff;

   logic       out_free;
   logic [7:0] up;
   logic [7:0] left;
   logic [7:0] upleft;
   logic [8:0] avg_sum;
   logic [7:0] predict;
   logic [7:0] recon;

   // result register can take a new transaction
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign b_take   = out_free;

   // neighbors, zero outside the image
   always_comb begin
      up      = b_item.first_row ? 8'd0 : up_byte;
      left    = b_item.first_pixel ? 8'd0 : left_ff[BYTES_PER_PIXEL-1];
      upleft  = b_item.first_pixel ? 8'd0 : upleft_ff[BYTES_PER_PIXEL-1];
      avg_sum = {1'b0, left} + {1'b0, up};
   end

   // predictor select
   always_comb begin
      case (b_item.filter)
         FLT_NONE:  predict = 8'd0;
         FLT_SUB:   predict = left;
         FLT_UP:    predict = up;
         FLT_AVG:   predict = avg_sum[8:1];
         FLT_PAETH: predict = paeth_pick(left, up, upleft);
         default:   predict = 8'd0;
      endcase
      recon = b_item.raw + predict;
   end

   // write back to the line store as the sample leaves
   assign wr_en   = b_valid & out_free;
   assign wr_addr = b_addr;
   assign wr_data = recon;

   // one pixel of history for left and up-left
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff[0]   <= recon;
         upleft_ff[0] <= up;
         for (int i = 1; i < BYTES_PER_PIXEL; i++) begin
            left_ff[i]   <= left_ff[i-1];
            upleft_ff[i] <= upleft_ff[i-1];
         end
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_pixel_byte_ff <= recon;
         rsp_row_end_ff    <= b_item.row_end;
         rsp_image_end_ff  <= b_item.image_end;
         rsp_bad_filter_ff <= (b_item.filter == FLT_BAD);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_byte_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;
   assign rsp_bad_filter = rsp_bad_filter_ff;

   // the last byte of an image is also the last of its row
   a_image_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_image_end_ff |-> rsp_row_end_ff)
      else $error("image end without row end");

   // every sample written back shows up as a result
   a_write_gives_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff)
      else $error("reconstructed sample not presented");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench for the png scanline unfilter: byte-level predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module tb_top;
   import pus_pkg::*;

   localparam int BPP             = DEF_BYTES_PER_PIXEL;
   localparam int MAX_PIXELS      = DEF_MAX_WIDTH;
   localparam int LINE_BYTES      = MAX_PIXELS * BPP;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam logic [7:0] CODE_TOP = 8'hFF;

   typedef struct {
      logic [7:0] pixel;
      logic       row_end;
      logic       image_end;
      logic       bad_filter;
   } pixel_result;

   typedef enum int {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // predictor of the unfilter plus the queue of pixels it still owes
   class scanline_scoreboard;
      logic [7:0]                prev_row [LINE_BYTES];
      logic [7:0]                left_px [BPP];
      logic [7:0]                upleft_px [BPP];
      filter_type                row_filter;
      int unsigned               column;
      int unsigned               row_num;
      bit                        want_filter;
      bit                        top_row;
      logic [IMAGE_WIDTH_W-1:0]  width_reg;
      logic [IMAGE_HEIGHT_W-1:0] height_reg;
      pixel_result               pixels_due [$];
      int unsigned               checked;
      int unsigned               mismatches;
      int unsigned               rows_done;
      int unsigned               images_done;
      int unsigned               bad_rows;

      function new();
         foreach (prev_row[i]) prev_row[i] = 8'h00;
         foreach (left_px[i]) begin
            left_px[i]   = 8'h00;
            upleft_px[i] = 8'h00;
         end
         row_filter  = FLT_NONE;
         column      = 0;
         row_num     = 0;
         want_filter = 1'b1;
         top_row     = 1'b1;
         width_reg   = 1;
         height_reg  = 1;
         checked     = 0;
         mismatches  = 0;
         rows_done   = 0;
         images_done = 0;
         bad_rows    = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void set_register(logic index, int unsigned value);
         if (index == REG_IMAGE_WIDTH) width_reg = IMAGE_WIDTH_W'(value);
         else height_reg = IMAGE_HEIGHT_W'(value);
      endfunction

      function void check_register(logic index, logic [CSR_DATA_W-1:0] got);
         logic [CSR_DATA_W-1:0] want;
         want = (index == REG_IMAGE_WIDTH) ? CSR_DATA_W'(width_reg) : CSR_DATA_W'(height_reg);
         if (got !== want)
            flag($sformatf("register %0d reads %0h, expected %0h", index, got, want));
      endfunction

      // nearest of left, up, up-left to their linear estimate
      function int paeth_choice(int a, int b, int c);
         int est, da, db, dc;
         est = a + b - c;
         da  = (est > a) ? est - a : a - est;
         db  = (est > b) ? est - b : b - est;
         dc  = (est > c) ? est - c : c - est;
         if (da <= db && da <= dc) return a;
         if (db <= dc) return b;
         return c;
      endfunction

      // one accepted stream byte: a filter byte or a sample to reconstruct
      function void unfilter_byte(logic [7:0] raw);
         int unsigned stride, rows, x, k;
         int          up, left, upleft, pred;
         pixel_result r;
         if (want_filter) begin
            row_filter  = (raw > FILTER_MAX) ? FLT_BAD : filter_type'(raw[2:0]);
            if (row_filter == FLT_BAD) bad_rows++;
            want_filter = 1'b0;
            column      = 0;
            foreach (left_px[i]) begin
               left_px[i]   = 8'h00;
               upleft_px[i] = 8'h00;
            end
            return;
         end
         stride = (width_reg == 0) ? 1 : (width_reg > MAX_PIXELS) ? MAX_PIXELS : width_reg;
         stride = stride * BPP;
         rows   = (height_reg == 0) ? 1 : height_reg;
         x      = column % LINE_BYTES;
         k      = x % BPP;
         up     = top_row ? 0 : prev_row[x];
         left   = left_px[k];
         upleft = upleft_px[k];
         case (row_filter)
            FLT_NONE:  pred = 0;
            FLT_SUB:   pred = left;
            FLT_UP:    pred = up;
            FLT_AVG:   pred = (left + up) / 2;
            FLT_PAETH: pred = paeth_choice(left, up, upleft);
            default:   pred = 0;
         endcase
         r.pixel      = 8'(raw + pred);
         r.bad_filter = (row_filter == FLT_BAD);
         r.row_end    = 1'b0;
         r.image_end  = 1'b0;
         left_px[k]   = r.pixel;
         upleft_px[k] = 8'(up);
         prev_row[x]  = r.pixel;
         // row and image bookkeeping
         if (column + 1 >= stride) begin
            r.row_end   = 1'b1;
            column      = 0;
            want_filter = 1'b1;
            top_row     = 1'b0;
            rows_done++;
            row_num = (row_num + 1) & 32'hFFFF;
            if (row_num >= rows || row_num == 0) begin
               r.image_end = 1'b1;
               row_num     = 0;
               top_row     = 1'b1;
               images_done++;
            end
         end else begin
            column++;
         end
         pixels_due.push_back(r);
      endfunction

      function void check_pixel(pixel_result got);
         pixel_result want;
         checked++;
         if (pixels_due.size() == 0) begin
            flag($sformatf("result %0d with nothing pending: pixel %02h ends %0b%0b bad %0b",
                           checked, got.pixel, got.row_end, got.image_end, got.bad_filter));
            return;
         end
         want = pixels_due.pop_front();
         if (got.pixel !== want.pixel)
            flag($sformatf("result %0d pixel_byte %02h, expected %02h",
                           checked, got.pixel, want.pixel));
         if (got.row_end !== want.row_end)
            flag($sformatf("result %0d row_end %0b, expected %0b",
                           checked, got.row_end, want.row_end));
         if (got.image_end !== want.image_end)
            flag($sformatf("result %0d image_end %0b, expected %0b",
                           checked, got.image_end, want.image_end));
         if (got.bad_filter !== want.bad_filter)
            flag($sformatf("result %0d bad_filter %0b, expected %0b",
                           checked, got.bad_filter, want.bad_filter));
      endfunction

      function int unsigned outstanding();
         return pixels_due.size();
      endfunction

      function void report_leftovers();
         if (pixels_due.size() != 0)
            flag($sformatf("%0d pixel bytes never arrived", pixels_due.size()));
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [7:0]            req_data_byte  = 8'h00;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [7:0]            rsp_pixel_byte;
   logic                  rsp_row_end;
   logic                  rsp_image_end;
   logic                  rsp_bad_filter;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   scanline_scoreboard board;
   idle_mode_type      idle_mode    = IDLE_OFF;
   int unsigned        hold_request = 0;
   int unsigned        hold_left    = 0;
   int unsigned        quiet_cycles = 0;
   int unsigned        bytes_sent   = 0;

   png_scanline_unfilter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   // result side: check each transaction, then pick the next stall
   always @(posedge clock) begin
      pixel_result got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pixel      = rsp_pixel_byte;
         got.row_end    = rsp_row_end;
         got.image_end  = rsp_image_end;
         got.bad_filter = rsp_bad_filter;
         board.check_pixel(got);
      end
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_stall <= ($urandom_range(0, 99) < 46);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // register write with read-back
   task automatic csr_write(input logic index, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_register(index, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.check_register(index, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one byte into the block, with random gaps before it
   task automatic send_byte(input logic [7:0] value);
      int unsigned rest_pct;
      rest_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 25 : 0;
      while ($urandom_range(0, 99) < rest_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.unfilter_byte(value);
      bytes_sent++;
   endtask

   function automatic logic [7:0] random_sample();
      case ($urandom_range(0, 19))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly legal filters, some bad codes across the whole range
   function automatic logic [7:0] random_code();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 17) return 8'($urandom_range(0, FILTER_MAX));
      if (pick == 17) return FILTER_MAX + 8'd1;
      return 8'($urandom_range(FILTER_MAX + 2, CODE_TOP));
   endfunction

   task automatic send_row(input logic [7:0] code, input int unsigned row_len);
      send_byte(code);
      repeat (row_len) send_byte(random_sample());
   endtask

   task automatic send_single_pixel_row(input logic [7:0] code, input logic [31:0] rgba);
      send_byte(code);
      for (int i = 3; i >= 0; i--) send_byte(rgba[8*i +: 8]);
   endtask

   // drop valid, wait for every owed pixel, then let the pipe go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_images(input int unsigned width, input int unsigned height,
                             input int unsigned count, input idle_mode_type mode);
      int unsigned row_len, rows;
      row_len   = ((width == 0) ? 1 : (width > MAX_PIXELS) ? MAX_PIXELS : width) * BPP;
      rows      = (height == 0) ? 1 : height;
      idle_mode = mode;
      csr_write(REG_IMAGE_WIDTH, width);
      csr_write(REG_IMAGE_HEIGHT, height);
      repeat (count * rows) send_row(random_code(), row_len);
      settle();
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: one pixel, one row
      send_single_pixel_row(8'(FLT_NONE), 32'h00FF55AA);
      settle();

      // single pixel column, Sub, Up, Average, Paeth and a bad code down the rows
      csr_write(REG_IMAGE_WIDTH, 1);
      csr_write(REG_IMAGE_HEIGHT, 5);
      send_single_pixel_row(8'(FLT_SUB), 32'h01FF807F);
      send_single_pixel_row(8'(FLT_UP), 32'h01FF0080);
      send_single_pixel_row(8'(FLT_AVG), 32'hFFFF0001);
      send_single_pixel_row(8'(FLT_PAETH), 32'h00FF7F80);
      send_single_pixel_row(CODE_TOP, 32'h12EF00FF);
      settle();

      // random images over several geometries and idling patterns
      run_images(3, 4, 2, IDLE_OFF);
      run_images(2, 5, 2, IDLE_SENDER);
      run_images(0, 0, 6, IDLE_RECEIVER);
      run_images(5, 3, 2, IDLE_BOTH);

      // tallest height, cut short by lowering it between rows
      idle_mode = IDLE_BOTH;
      csr_write(REG_IMAGE_WIDTH, 4);
      csr_write(REG_IMAGE_HEIGHT, 65535);
      repeat (3) send_row(random_code(), 4 * BPP);
      settle();
      csr_write(REG_IMAGE_HEIGHT, 2);
      send_row(random_code(), 4 * BPP);
      settle();

      // receiver holds off while the sender keeps pushing
      hold_request = HOLD_OFF_CYCLES;
      run_images(6, 3, 1, IDLE_OFF);

      run_images(1, 1, 10, IDLE_OFF);

      // catch late strays
      repeat (20) @(posedge clock);
      board.report_leftovers();
      $display("sent %0d bytes, checked %0d pixel bytes in %0d rows of %0d images",
               bytes_sent, board.checked, board.rows_done, board.images_done);
      $display("widths 0 to 6, heights 0 to 65535, all filters, %0d bad-code rows, stalls",
               board.bad_rows);
      if (board.mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

[png_scanline_unfilter.f]
sv/pus_pkg.sv
sv/pus_ram.sv
sv/pus_ctrl.sv
sv/pus_recon.sv
sv/png_scanline_unfilter.sv
tb/tb_top.sv
